/* design/segment_display_update_engine_unit_assert.svh */
// Assertion macros used by the RTL controller (sdue_ctrl).
`ifndef SEGMENT_DISPLAY_UPDATE_ENGINE_UNIT_ASSERT_SVH
`define SEGMENT_DISPLAY_UPDATE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDUE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDUE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sdue_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdue_pkg;

    localparam logic [2:0] OP_CHAR   = 3'd0;
    localparam logic [2:0] OP_DIGIT  = 3'd1;
    localparam logic [2:0] OP_ICON   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_SWITCH = 3'd4;

    localparam logic [7:0] ADDR_BASE = 8'hC0;
    localparam logic [7:0] CMD_SHOW  = 8'h8F;
    localparam logic [7:0] CMD_BLANK = 8'h87;
    localparam logic [7:0] CMD_MODE  = 8'h0C;
    localparam logic [7:0] CMD_WRITE = 8'h44;

    localparam logic [7:0] TEXT_POS_MAX    = 8'd8;
    localparam logic [7:0] CLOCK_POS_MAX   = 8'd4;
    localparam logic [7:0] DIGIT_VALUE_MAX = 8'd9;
    localparam logic [7:0] ICON_COUNT      = 8'd45;
    localparam logic [7:0] ICONS_PER_DIGIT = 8'd15;

    // Only digits 9..13 are ever read back; they are the only ones kept.
    localparam int SHADOW_FIRST     = 9;
    localparam int SHADOW_DIGITS    = 5;
    localparam int SHADOW_IDX_W     = 3;
    localparam int ICON_DIGIT_FIRST = 11;
    localparam int DIGIT_W          = 5;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] symbol_code;
        logic [7:0] position;
        logic [7:0] icon_number;
        logic       turn_on;
    } cmd_item_t;

    typedef struct packed {
        logic       frame_kind;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       last;
    } frame_item_t;

    typedef enum logic [3:0] {
        FS_NONE,
        FS_CHAR0,
        FS_CHAR1,
        FS_DIG0,
        FS_DIG1,
        FS_ICON,
        FS_MODE,
        FS_WRITE,
        FS_CLR0,
        FS_CLR1,
        FS_SHOW,
        FS_SHOW_LAST,
        FS_SWITCH
    } frame_sel_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       digit_inc;
        frame_sel_t sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic       in_ok;
        logic [2:0] in_op;
        logic       slot_free;
        logic       digit_last;
    } dp_sts_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] idx;
    } char_sel_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] off;
        logic       seg;
        logic [2:0] bit_pos;
    } icon_sel_t;

    function automatic char_sel_t char_lookup(input logic [7:0] code);
        char_sel_t res;
        res = '0;
        if (code >= 8'd65 && code <= 8'd95) begin
            res.ok  = 1'b1;
            res.idx = 6'(code - 8'd65);
        end else if (code >= 8'd97 && code <= 8'd122) begin
            res.ok  = 1'b1;
            res.idx = 6'(code - 8'd97);
        end else if (code >= 8'd42 && code <= 8'd57) begin
            res.ok  = 1'b1;
            res.idx = 6'(code - 8'd11);
        end else if (code == 8'd32) begin
            res.ok  = 1'b1;
            res.idx = 6'd47;
        end
        return res;
    endfunction

    function automatic logic [15:0] font_glyph(input logic [5:0] idx);
        logic [15:0] g;
        case (idx)
            6'd0:  g = 16'hF138;
            6'd1:  g = 16'h7472;
            6'd2:  g = 16'h0168;
            6'd3:  g = 16'h5472;
            6'd4:  g = 16'hE168;
            6'd5:  g = 16'hE128;
            6'd6:  g = 16'h7168;
            6'd7:  g = 16'hF118;
            6'd8:  g = 16'h4462;
            6'd9:  g = 16'h4522;
            6'd10: g = 16'h4606;
            6'd11: g = 16'h0148;
            6'd12: g = 16'h511D;
            6'd13: g = 16'h5319;
            6'd14: g = 16'h1178;
            6'd15: g = 16'hE138;
            6'd16: g = 16'h1378;
            6'd17: g = 16'hE338;
            6'd18: g = 16'hF068;
            6'd19: g = 16'h4422;
            6'd20: g = 16'h1158;
            6'd21: g = 16'h490C;
            6'd22: g = 16'h5B18;
            6'd23: g = 16'h4A05;
            6'd24: g = 16'h4405;
            6'd25: g = 16'h4864;
            6'd26: g = 16'h0168;
            6'd27: g = 16'h4201;
            6'd28: g = 16'h1070;
            6'd29: g = 16'h4309;
            6'd30: g = 16'hE000;
            6'd31: g = 16'hEE07;
            6'd32: g = 16'hE402;
            6'd33: g = 16'h5000;
            6'd34: g = 16'hE000;
            6'd35: g = 16'h0500;
            6'd36: g = 16'h4804;
            6'd37: g = 16'h1178;
            6'd38: g = 16'h4402;
            6'd39: g = 16'hE170;
            6'd40: g = 16'hF070;
            6'd41: g = 16'hF018;
            6'd42: g = 16'hF068;
            6'd43: g = 16'hF168;
            6'd44: g = 16'h1030;
            6'd45: g = 16'hF178;
            6'd46: g = 16'hF078;
            default: g = 16'h0000;
        endcase
        return g;
    endfunction

    function automatic logic [15:0] num_glyph(input logic [3:0] value);
        logic [15:0] g;
        case (value)
            4'd0: g = 16'h7777;
            4'd1: g = 16'h2422;
            4'd2: g = 16'h6B6D;
            4'd3: g = 16'h6D6B;
            4'd4: g = 16'h3C3A;
            4'd5: g = 16'h5D5B;
            4'd6: g = 16'h5F5F;
            4'd7: g = 16'h6462;
            4'd8: g = 16'h7F7F;
            4'd9: g = 16'h7D7B;
            default: g = 16'h0000;
        endcase
        return g;
    endfunction

    function automatic icon_sel_t icon_decode(input logic [7:0] num);
        icon_sel_t  res;
        logic [7:0] k;
        logic [7:0] r;
        res = '0;
        k = num - 8'd1;
        res.ok = (num >= 8'd1) && (num <= ICON_COUNT);
        if (k < ICONS_PER_DIGIT) begin
            res.off = 2'd0;
            r = k;
        end else if (k < 8'(2 * ICONS_PER_DIGIT)) begin
            res.off = 2'd1;
            r = k - ICONS_PER_DIGIT;
        end else begin
            res.off = 2'd2;
            r = k - 8'(2 * ICONS_PER_DIGIT);
        end
        if (r < 8'd8) begin
            res.seg     = 1'b0;
            res.bit_pos = r[2:0];
        end else begin
            res.seg     = 1'b1;
            res.bit_pos = 3'(r - 8'd8);
        end
        return res;
    endfunction

    function automatic logic [7:0] seg_addr(input logic [DIGIT_W-1:0] digit, input logic seg);
        logic [7:0] d;
        d = 8'(digit) - 8'd1;
        return ADDR_BASE + (d * 8'd3) + {7'b0, seg};
    endfunction

endpackage

`default_nettype wire

/* design/sdue_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdue_dp
    import sdue_pkg::*;
#(
    parameter int NUM_DIGITS = 13
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_item_t   cmd_data,
    input  wire ctl_cmd_t    ctl,
    output dp_sts_t          sts,
    input  wire logic        frame_stall,
    output logic             frame_valid,
    output frame_item_t      frame_data
);

    localparam int DIG_W = $clog2(NUM_DIGITS + 1);

    cmd_item_t   item_reg;
    frame_item_t frame_reg;
    logic        frame_valid_reg;
    logic        frame_valid_next;
    logic [DIG_W-1:0] digit_reg;
    logic [7:0]  shadow_reg [SHADOW_DIGITS-1:0][1:0];

    char_sel_t   in_char;
    icon_sel_t   in_icon;
    char_sel_t   cur_char;
    icon_sel_t   cur_icon;
    logic [15:0] char_glyph;
    logic [15:0] dig_glyph;
    logic [SHADOW_IDX_W-1:0] dig_idx;
    logic [SHADOW_IDX_W-1:0] icon_idx;
    logic [DIGIT_W-1:0] dig_num;
    logic [DIGIT_W-1:0] icon_num;
    logic        odd;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  new0_odd;
    logic [7:0]  new1_odd;
    logic [7:0]  new0_even;
    logic [7:0]  new1_even;
    logic [7:0]  icon_cur;
    logic [7:0]  icon_mask;

    frame_item_t frame_next;
    logic        wr_en;
    logic [SHADOW_IDX_W-1:0] wr_idx;
    logic        wr_seg;
    logic [7:0]  wr_val;

    always_comb
    begin
        in_char = char_lookup(cmd_data.symbol_code);
        in_icon = icon_decode(cmd_data.icon_number);
        sts.in_op = cmd_data.op;
        unique case (cmd_data.op) inside
            OP_CHAR:
            begin
                sts.in_ok = (cmd_data.position >= 8'd1) && (cmd_data.position <= TEXT_POS_MAX)
                    && in_char.ok;
            end
            OP_DIGIT:
            begin
                sts.in_ok = (cmd_data.position >= 8'd1) && (cmd_data.position <= CLOCK_POS_MAX)
                    && (cmd_data.symbol_code <= DIGIT_VALUE_MAX);
            end
            OP_ICON:
            begin
                sts.in_ok = in_icon.ok && ((int'(in_icon.off) + ICON_DIGIT_FIRST) <= NUM_DIGITS);
            end
            OP_CLEAR, OP_SWITCH:
            begin
                sts.in_ok = 1'b1;
            end
            default:
            begin
                sts.in_ok = 1'b0;
            end
        endcase
        sts.slot_free  = !frame_valid_reg || !frame_stall;
        sts.digit_last = (digit_reg == DIG_W'(NUM_DIGITS));
    end

    always_comb
    begin
        cur_char   = char_lookup(item_reg.symbol_code);
        cur_icon   = icon_decode(item_reg.icon_number);
        char_glyph = font_glyph(cur_char.idx);
        dig_glyph  = num_glyph(item_reg.symbol_code[3:0]);
        odd        = item_reg.position[0];
        dig_idx    = (item_reg.position <= 8'd2) ? SHADOW_IDX_W'(1) : SHADOW_IDX_W'(0);
        dig_num    = DIGIT_W'(SHADOW_FIRST) + DIGIT_W'(dig_idx);
        icon_idx   = SHADOW_IDX_W'(ICON_DIGIT_FIRST - SHADOW_FIRST) + SHADOW_IDX_W'(cur_icon.off);
        icon_num   = DIGIT_W'(ICON_DIGIT_FIRST) + DIGIT_W'(cur_icon.off);
        c0         = shadow_reg[dig_idx][0];
        c1         = shadow_reg[dig_idx][1];
        new0_odd   = {dig_glyph[0], c0[6:0]};
        new1_odd   = {1'b0, dig_glyph[7] | c1[6], dig_glyph[6:1]};
        new1_even  = {c1[7] & dig_glyph[8], dig_glyph[8], c1[5:0]};
        new0_even  = {c0[7], dig_glyph[15:9]};
        icon_cur   = shadow_reg[icon_idx][cur_icon.seg];
        icon_mask  = 8'd1 << cur_icon.bit_pos;

        frame_next = '0;
        wr_en      = 1'b0;
        wr_idx     = '0;
        wr_seg     = 1'b0;
        wr_val     = '0;
        case (ctl.sel)
            FS_CHAR0:
            begin
                frame_next.frame_kind  = 1'b1;
                frame_next.first_byte  = seg_addr(item_reg.position[DIGIT_W-1:0], 1'b0);
                frame_next.second_byte = char_glyph[15:8];
            end
            FS_CHAR1:
            begin
                frame_next.frame_kind  = 1'b1;
                frame_next.first_byte  = seg_addr(item_reg.position[DIGIT_W-1:0], 1'b1);
                frame_next.second_byte = char_glyph[7:0];
            end
            FS_DIG0:
            begin
                wr_en  = 1'b1;
                wr_idx = dig_idx;
                wr_seg = !odd;
                wr_val = odd ? new0_odd : new1_even;
                frame_next.frame_kind  = 1'b1;
                frame_next.first_byte  = seg_addr(dig_num, wr_seg);
                frame_next.second_byte = wr_val;
            end
            FS_DIG1:
            begin
                wr_en  = 1'b1;
                wr_idx = dig_idx;
                wr_seg = odd;
                wr_val = odd ? new1_odd : new0_even;
                frame_next.frame_kind  = 1'b1;
                frame_next.first_byte  = seg_addr(dig_num, wr_seg);
                frame_next.second_byte = wr_val;
            end
            FS_ICON:
            begin
                wr_en  = 1'b1;
                wr_idx = icon_idx;
                wr_seg = cur_icon.seg;
                wr_val = item_reg.turn_on ? (icon_cur | icon_mask) : (icon_cur & ~icon_mask);
                frame_next.frame_kind  = 1'b1;
                frame_next.first_byte  = seg_addr(icon_num, wr_seg);
                frame_next.second_byte = wr_val;
            end
            FS_MODE:
            begin
                frame_next.first_byte = CMD_MODE;
            end
            FS_WRITE:
            begin
                frame_next.first_byte = CMD_WRITE;
            end
            FS_CLR0:
            begin
                frame_next.frame_kind = 1'b1;
                frame_next.first_byte = seg_addr(DIGIT_W'(digit_reg), 1'b0);
            end
            FS_CLR1:
            begin
                frame_next.frame_kind = 1'b1;
                frame_next.first_byte = seg_addr(DIGIT_W'(digit_reg), 1'b1);
            end
            FS_SHOW:
            begin
                frame_next.first_byte = CMD_SHOW;
            end
            FS_SHOW_LAST:
            begin
                frame_next.first_byte = CMD_SHOW;
                frame_next.last       = 1'b1;
            end
            FS_SWITCH:
            begin
                frame_next.first_byte = item_reg.turn_on ? CMD_SHOW : CMD_BLANK;
                frame_next.last       = 1'b1;
            end
            default:
            begin
                frame_next = '0;
            end
        endcase

        if (ctl.emit)
        begin
            frame_valid_next = 1'b1;
        end
        else
        begin
            frame_valid_next = frame_valid_reg && frame_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= cmd_data;
        end
        if (ctl.emit)
        begin
            frame_reg <= frame_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            digit_reg       <= '0;
            for (int i = 0; i < SHADOW_DIGITS; i++)
            begin
                shadow_reg[i][0] <= '0;
                shadow_reg[i][1] <= '0;
            end
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
            if (ctl.load)
            begin
                digit_reg <= DIG_W'(1);
            end
            else if (ctl.emit && ctl.digit_inc)
            begin
                digit_reg <= digit_reg + DIG_W'(1);
            end
            if (ctl.emit && (ctl.sel == FS_MODE))
            begin
                for (int i = 0; i < SHADOW_DIGITS; i++)
                begin
                    shadow_reg[i][0] <= '0;
                    shadow_reg[i][1] <= '0;
                end
            end
            else if (ctl.emit && wr_en)
            begin
                shadow_reg[wr_idx][wr_seg] <= wr_val;
            end
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_data  = frame_reg;

endmodule

`default_nettype wire

/* design/sdue_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "segment_display_update_engine_unit_assert.svh"

module sdue_ctrl
    import sdue_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    output logic         cmd_stall,
    input  wire dp_sts_t sts,
    output ctl_cmd_t     ctl
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_CHAR0  = 14'b00000000000010,
        ST_CHAR1  = 14'b00000000000100,
        ST_DIG0   = 14'b00000000001000,
        ST_DIG1   = 14'b00000000010000,
        ST_ICON   = 14'b00000000100000,
        ST_MODE   = 14'b00000001000000,
        ST_WRITE  = 14'b00000010000000,
        ST_CLR0   = 14'b00000100000000,
        ST_SHOW0  = 14'b00001000000000,
        ST_CLR1   = 14'b00010000000000,
        ST_SHOW1  = 14'b00100000000000,
        ST_DONE   = 14'b01000000000000,
        ST_SWITCH = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   final_emit;

    always_comb
    begin
        state_next    = state_reg;
        ctl.load      = 1'b0;
        ctl.digit_inc = 1'b0;
        ctl.sel       = FS_NONE;
        ctl.emit      = (state_reg != ST_IDLE) && sts.slot_free;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load = 1'b1;
                    if (sts.in_ok)
                    begin
                        unique case (sts.in_op)
                            OP_CHAR:   state_next = ST_CHAR0;
                            OP_DIGIT:  state_next = ST_DIG0;
                            OP_ICON:   state_next = ST_ICON;
                            OP_CLEAR:  state_next = ST_MODE;
                            OP_SWITCH: state_next = ST_SWITCH;
                            default:   state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_CHAR0:
            begin
                ctl.sel = FS_CHAR0;
                if (ctl.emit) state_next = ST_CHAR1;
            end
            ST_CHAR1:
            begin
                ctl.sel = FS_CHAR1;
                if (ctl.emit) state_next = ST_DONE;
            end
            ST_DIG0:
            begin
                ctl.sel = FS_DIG0;
                if (ctl.emit) state_next = ST_DIG1;
            end
            ST_DIG1:
            begin
                ctl.sel = FS_DIG1;
                if (ctl.emit) state_next = ST_DONE;
            end
            ST_ICON:
            begin
                ctl.sel = FS_ICON;
                if (ctl.emit) state_next = ST_DONE;
            end
            ST_MODE:
            begin
                ctl.sel = FS_MODE;
                if (ctl.emit) state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctl.sel = FS_WRITE;
                if (ctl.emit) state_next = ST_CLR0;
            end
            ST_CLR0:
            begin
                ctl.sel = FS_CLR0;
                if (ctl.emit) state_next = ST_SHOW0;
            end
            ST_SHOW0:
            begin
                ctl.sel = FS_SHOW;
                if (ctl.emit) state_next = ST_CLR1;
            end
            ST_CLR1:
            begin
                ctl.sel = FS_CLR1;
                if (ctl.emit) state_next = ST_SHOW1;
            end
            ST_SHOW1:
            begin
                ctl.sel       = FS_SHOW;
                ctl.digit_inc = 1'b1;
                if (ctl.emit) state_next = sts.digit_last ? ST_DONE : ST_CLR0;
            end
            ST_DONE:
            begin
                ctl.sel = FS_SHOW_LAST;
                if (ctl.emit) state_next = ST_IDLE;
            end
            ST_SWITCH:
            begin
                ctl.sel = FS_SWITCH;
                if (ctl.emit) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign final_emit = ctl.emit && (ctl.sel == FS_SHOW_LAST || ctl.sel == FS_SWITCH);

    `SDUE_ASSERT_NOW(a_no_emit_idle, state_reg == ST_IDLE, !ctl.emit, "frame issued while idle")
    `SDUE_ASSERT_NOW(a_emit_slot_free, ctl.emit, sts.slot_free, "frame issued into full slot")
    `SDUE_ASSERT_NEXT(a_last_to_idle, final_emit, state_reg == ST_IDLE, "no idle after last frame")

endmodule

`default_nettype wire

/* design/segment_display_update_engine_unit.sv */
// Segment display update engine.
// Command channel (cmd_valid / cmd_stall / cmd_data) takes one display command;
// a transfer happens on a clock edge with cmd_valid high and cmd_stall low.
// Frame channel (frame_valid / frame_stall / frame_data) delivers controller
// frames, one per transfer, with last set on the final frame of a command.
// A command is taken only while the sequencer is idle; commands with bad
// arguments are taken and produce no frames.
// The first frame is registered from the first sequencer state after the
// command transfer; each further frame follows when the receiver does not
// stall. A command yields three frames for draw char and draw digit, two for
// icon, one for display switch and 4*NUM_DIGITS+3 for clear all. The frame
// sequencer emits into a single output register.
// The next command is accepted while the last frame still waits in the
// output register. A stall holds the frame register and the sequencer.
// Reset clears the shadow of the clock and icon digits, empties the output
// register and returns the sequencer to idle; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module segment_display_update_engine_unit
    import sdue_pkg::*;
#(
    parameter int NUM_DIGITS = 13
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd_data,
    output logic           frame_valid,
    input  wire logic      frame_stall,
    output frame_item_t    frame_data
);

    ctl_cmd_t ctl;
    dp_sts_t  sts;

    sdue_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    sdue_dp #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_data    (cmd_data),
        .ctl         (ctl),
        .sts         (sts),
        .frame_stall (frame_stall),
        .frame_valid (frame_valid),
        .frame_data  (frame_data)
    );

endmodule

`default_nettype wire
